/* hw/rtl/drtsc_pkg.sv */
`default_nettype none

package drtsc_pkg;

    // Kinds of input transaction, carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Register offsets within the timer's I/O window.
    localparam logic [3:0] OFF_SERIAL_CTRL = 4'd2;
    localparam logic [3:0] OFF_DIVIDER     = 4'd4;
    localparam logic [3:0] OFF_COUNTER     = 4'd5;
    localparam logic [3:0] OFF_MODULO      = 4'd6;
    localparam logic [3:0] OFF_CONTROL     = 4'd7;

    localparam logic [7:0] CONTROL_RESET      = 8'hF8;
    localparam logic [7:0] READ_UNMAPPED      = 8'hFF;
    localparam logic [7:0] COUNTER_TOP        = 8'hFF;
    localparam logic [7:0] RELOAD_BELOW       = 8'd5;
    localparam logic [9:0] SINGLE_CARRY_LIMIT = 10'h0FF;
    localparam logic [9:0] DOUBLE_CARRY_LIMIT = 10'h1FE;
    localparam int unsigned CONTROL_ENABLE_BIT = 2;
    localparam int unsigned SERIAL_START_BIT   = 7;

    // One input item.
    typedef struct packed {
        cmd_t       command;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
        logic [2:0] mcycles;
    } item_t;

    // One result item, packed in output tdata order (read_data lowest).
    typedef struct packed {
        logic       serial_irq;
        logic       timer_irq;
        logic [7:0] read_data;
    } result_t;

    // Counter prescaler shift for each timer mode.
    function automatic logic [2:0] mode_shift(input logic [1:0] mode);
        logic [2:0] shift;
        case (mode)
            2'd0: shift = 3'd0;
            2'd1: shift = 3'd6;
            2'd2: shift = 3'd4;
            default: shift = 3'd2;
        endcase
        return shift;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/drtsc_timer.sv */
`default_nettype none

module drtsc_timer
    import drtsc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    item_valid,
    input  wire item_t   item,
    output result_t      result
);

    logic [7:0] divider_prescale_reg, divider_prescale_next;
    logic [7:0] divider_reg, divider_next;
    logic [7:0] counter_prescale_reg, counter_prescale_next;
    logic [7:0] counter_reg, counter_next;
    logic [7:0] counter_previous_reg, counter_previous_next;
    logic [7:0] modulo_reg, modulo_next;
    logic [7:0] control_byte_reg, control_byte_next;
    logic [7:0] serial_control_reg, serial_control_next;
    logic       serial_busy_reg, serial_busy_next;
    logic [3:0] serial_bump_count_reg, serial_bump_count_next;

    logic [8:0] div_sum;
    logic [9:0] cnt_step;
    logic [9:0] cnt_sum;
    logic [7:0] counter_bumped;

    // Adders for the two prescalers.
    assign div_sum  = {1'b0, divider_prescale_reg} + {4'b0, item.mcycles, 2'b00};
    assign cnt_step = {7'b0, item.mcycles} << mode_shift(control_byte_reg[1:0]);
    assign cnt_sum  = {2'b0, counter_prescale_reg} + cnt_step;
    assign counter_bumped = counter_reg + 8'(cnt_sum > SINGLE_CARRY_LIMIT)
                          + 8'(cnt_sum > DOUBLE_CARRY_LIMIT);

    // Next state and result for the transaction at the input.
    always_comb begin
        divider_prescale_next  = divider_prescale_reg;
        divider_next           = divider_reg;
        counter_prescale_next  = counter_prescale_reg;
        counter_next           = counter_reg;
        counter_previous_next  = counter_previous_reg;
        modulo_next            = modulo_reg;
        control_byte_next      = control_byte_reg;
        serial_control_next    = serial_control_reg;
        serial_busy_next       = serial_busy_reg;
        serial_bump_count_next = serial_bump_count_reg;
        result                 = '0;

        case (item.command)
            CMD_TICK: begin
                divider_prescale_next = div_sum[7:0];
                if (div_sum[8]) begin
                    divider_next = divider_reg + 8'd1;
                    if (serial_busy_reg) begin
                        serial_bump_count_next = serial_bump_count_reg + 4'd1;
                        // The transfer ends when the bump count wraps to zero.
                        if (serial_bump_count_next == 4'd0) begin
                            serial_control_next = serial_control_reg & 8'h7F;
                            serial_busy_next    = 1'b0;
                            result.serial_irq   = 1'b1;
                        end
                    end
                end
                if (control_byte_reg[CONTROL_ENABLE_BIT]) begin
                    counter_prescale_next = cnt_sum[7:0];
                    counter_next          = counter_bumped;
                    // Reload only when the counter passed through its top value.
                    if (counter_bumped < RELOAD_BELOW && counter_previous_reg == COUNTER_TOP) begin
                        counter_next     = modulo_reg;
                        result.timer_irq = 1'b1;
                    end
                    counter_previous_next = counter_next;
                end
            end
            CMD_WRITE: begin
                case (item.reg_offset)
                    OFF_SERIAL_CTRL: begin
                        serial_control_next = item.write_data;
                        if (item.write_data[SERIAL_START_BIT]) begin
                            serial_busy_next = 1'b1;
                        end
                    end
                    OFF_DIVIDER: divider_next      = 8'd0;
                    OFF_COUNTER: counter_next      = item.write_data;
                    OFF_MODULO:  modulo_next       = item.write_data;
                    OFF_CONTROL: control_byte_next = item.write_data;
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (item.reg_offset)
                    OFF_SERIAL_CTRL: result.read_data = serial_control_reg;
                    OFF_DIVIDER:     result.read_data = divider_reg;
                    OFF_COUNTER:     result.read_data = counter_reg;
                    OFF_MODULO:      result.read_data = modulo_reg;
                    OFF_CONTROL:     result.read_data = control_byte_reg;
                    default:         result.read_data = READ_UNMAPPED;
                endcase
            end
            default: ;
        endcase
    end

    // State registers, updated on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_prescale_reg  <= 8'd0;
            divider_reg           <= 8'd0;
            counter_prescale_reg  <= 8'd0;
            counter_reg           <= 8'd0;
            counter_previous_reg  <= 8'd0;
            modulo_reg            <= 8'd0;
            control_byte_reg      <= CONTROL_RESET;
            serial_control_reg    <= 8'd0;
            serial_busy_reg       <= 1'b0;
            serial_bump_count_reg <= 4'd0;
        end else if (item_valid) begin
            divider_prescale_reg  <= divider_prescale_next;
            divider_reg           <= divider_next;
            counter_prescale_reg  <= counter_prescale_next;
            counter_reg           <= counter_next;
            counter_previous_reg  <= counter_previous_next;
            modulo_reg            <= modulo_next;
            control_byte_reg      <= control_byte_next;
            serial_control_reg    <= serial_control_next;
            serial_busy_reg       <= serial_busy_next;
            serial_bump_count_reg <= serial_bump_count_next;
        end
    end

    // A serial completion only comes from a busy transfer on its last bump.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && result.serial_irq) |-> (serial_busy_reg && serial_bump_count_reg == 4'hF))
        else $error("serial completion without a finishing transfer");

    // After a completion the transfer is idle and its start bit is clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && result.serial_irq) |=> (!serial_busy_reg && !serial_control_reg[7]))
        else $error("serial transfer still marked busy after completion");

    // A reload leaves the counter at the modulo value and records it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && result.timer_irq) |=>
            (counter_reg == $past(modulo_reg) && counter_previous_reg == counter_reg))
        else $error("timer reload did not load the modulo value");

endmodule

`default_nettype wire

/* hw/rtl/drtsc_skid.sv */
`default_nettype none

module drtsc_skid
    import drtsc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_load;

    // The input is open as long as the spare stage is empty.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = out_ready || !out_valid_reg;

    // Move results forward; park one in the spare stage on a stall.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The spare stage only fills behind a waiting output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare stage holds a result while the output is empty");

    // A parked result goes out next once the output drains.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && out_data_reg == $past(skid_data_reg)))
        else $error("parked result was not forwarded in order");

endmodule

`default_nettype wire

/* hw/rtl/divider_reload_timer_serial_clock_core.sv */
// Each result is registered in the output buffer when its input transaction is accepted.
// Throughput: one transaction per cycle while s_tready is high; all work done on acceptance.
// A two-entry output buffer lets the input keep flowing while one result waits.
// Reset (aresetn low, synchronous) clears all timer state, sets control to 0xF8 and
// empties the output buffer.
`default_nettype none

module divider_reload_timer_serial_clock_core
    import drtsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // reg_offset[3:0], write_data[11:4], mcycles[14:12]
    input  wire logic [1:0]  s_tuser,  // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // read_data[7:0], timer_irq[8], serial_irq[9]
);

    item_t   item;
    result_t result;
    result_t out_result;
    logic    accept;

    // Unpack the input transaction.
    assign item.command    = cmd_t'(s_tuser);
    assign item.reg_offset = s_tdata[3:0];
    assign item.write_data = s_tdata[11:4];
    assign item.mcycles    = s_tdata[14:12];
    assign accept          = s_tvalid && s_tready;

    drtsc_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item       (item),
        .result     (result)
    );

    drtsc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result transaction.
    assign m_tdata = {6'b0, out_result};

endmodule

`default_nettype wire
